FILE: hw/rtl/osl_pkg.sv
// Shared types, constants and helpers for the orthotropic plane-stress law.
// Used by every module of the block; depends on nothing else.
package osl_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int MOD_W     = 31;
  localparam int NU_W      = 18;
  localparam int CFG_IDX_W = 2;
  // Dividend width of the shared divider: |nu * Ey| stays below 2^48.
  localparam int DIV_W     = 48;
  localparam int CNT_W     = $clog2(DIV_W);
  localparam int DEN_W     = FRAC_BITS + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS_X  = 2'd0,
    CFG_MODULUS_Y  = 2'd1,
    CFG_POISSON_XY = 2'd2,
    CFG_SHEAR_MOD  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_START,
    ST_DIV_NUYX,
    ST_CHECK,
    ST_DIV_Q11,
    ST_DIV_Q22,
    ST_DIV_Q12,
    ST_DONE
  } stf_state_t;

  typedef struct packed {
    logic                     use_gradient;
    logic                     want_stress;
    logic                     want_tensor;
    logic signed [WORD_W-1:0] strain_xx;
    logic signed [WORD_W-1:0] strain_yy;
    logic signed [WORD_W-1:0] shear_strain;
    logic signed [WORD_W-1:0] grad_f11;
    logic signed [WORD_W-1:0] grad_f12;
    logic signed [WORD_W-1:0] grad_f21;
    logic signed [WORD_W-1:0] grad_f22;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] stress_xx;
    logic signed [WORD_W-1:0] stress_yy;
    logic signed [WORD_W-1:0] shear_stress;
    logic signed [WORD_W-1:0] strain_xx_out;
    logic signed [WORD_W-1:0] strain_yy_out;
    logic signed [WORD_W-1:0] shear_strain_out;
    logic signed [WORD_W-1:0] stiff_11;
    logic signed [WORD_W-1:0] stiff_12;
    logic signed [WORD_W-1:0] stiff_22;
    logic        [MOD_W-1:0]  stiff_66;
    logic        [1:0]        valid_kind;
    logic                     material_error;
  } out_word_t;

  // Stiffness terms handed from the stiffness unit to the stress pipeline.
  typedef struct packed {
    logic                     ready;
    logic                     err;
    logic signed [WORD_W-1:0] q11;
    logic signed [WORD_W-1:0] q12;
    logic signed [WORD_W-1:0] q22;
    logic        [MOD_W-1:0]  q66;
  } stiff_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [65:0] v);
    logic signed [WORD_W-1:0] r;
    if (v[65:WORD_W-1] == '0 || v[65:WORD_W-1] == '1) begin
      r = v[WORD_W-1:0];
    end else if (v[65]) begin
      r = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(WORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/osl_stiff.sv
// Configuration registers and reduced-stiffness unit with a shared radix-2 divider.
// Depends on osl_pkg.
module osl_stiff import osl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MOD_W-1:0]     cfg_wdata,
  output stiff_t               stf
);

  logic [MOD_W-1:0]       mod_x_r, mod_y_r, shear_r;
  logic signed [NU_W-1:0] nu_r;

  stf_state_t state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_W-1:0]  num_r;
  logic [MOD_W-1:0]  rem_r, dsr_r;
  logic signed [WORD_W-1:0] q11_r, q12_r, q22_r;
  logic err_r;

  logic [NU_W-1:0]    an;
  logic [DIV_W:0]     nuey_full;
  logic [DIV_W-1:0]   nuey_mag;
  logic [MOD_W:0]     rem_sh;
  logic               div_ge;
  logic [MOD_W-1:0]   rem_step;
  logic [DIV_W-1:0]   num_step;
  logic               div_last;
  logic [DIV_W+1:0]   prod;
  logic               chk_err;
  logic [DEN_W-1:0]   den;
  logic [WORD_W-1:0]  q_pos;
  logic [WORD_W-1:0]  q_neg;

  logic               div_load, div_run;
  logic [DIV_W-1:0]   ld_num;
  logic [MOD_W-1:0]   ld_dsr;
  logic               cap_q11, cap_q22, cap_q12;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_x_r <= MOD_W'(65536);
      mod_y_r <= MOD_W'(65536);
      nu_r    <= '0;
      shear_r <= MOD_W'(32768);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODULUS_X:  mod_x_r <= cfg_wdata;
        CFG_MODULUS_Y:  mod_y_r <= cfg_wdata;
        CFG_POISSON_XY: nu_r    <= cfg_wdata[NU_W-1:0];
        CFG_SHEAR_MOD:  shear_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign an        = nu_r[NU_W-1] ? NU_W'(-nu_r) : NU_W'(nu_r);
  assign nuey_full = (DIV_W+1)'(an) * (DIV_W+1)'(mod_y_r);
  assign nuey_mag  = nuey_full[DIV_W-1:0];

  // One quotient bit per cycle, restoring form.
  assign rem_sh   = {rem_r, num_r[DIV_W-1]};
  assign div_ge   = rem_sh >= {1'b0, dsr_r};
  assign rem_step = div_ge ? MOD_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[MOD_W-1:0];
  assign num_step = {num_r[DIV_W-2:0], div_ge};
  assign div_last = cnt_r == CNT_W'(DIV_W - 1);

  // After the first division num_r holds |nu_yx|.
  assign prod    = (DIV_W+2)'(an) * (DIV_W+2)'(num_r[2*FRAC_BITS-1:0]);
  assign chk_err = (an != '0 && num_r[DIV_W-1:2*FRAC_BITS] != '0)
                   || prod[DIV_W+1:2*FRAC_BITS] != '0;
  assign den     = DEN_W'(1 << FRAC_BITS) - {1'b0, prod[2*FRAC_BITS-1:FRAC_BITS]};

  assign q_pos = (num_step[DIV_W-1:WORD_W-1] != '0) ? {1'b0, {(WORD_W-1){1'b1}}}
                                                     : {1'b0, num_step[WORD_W-2:0]};
  assign q_neg = (num_step[DIV_W-1:WORD_W-1] != '0) ? {1'b1, {(WORD_W-1){1'b0}}}
                                                     : WORD_W'(-{1'b0, num_step[WORD_W-2:0]});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_START:    state_nxt = (mod_x_r == '0 || mod_y_r == '0) ? ST_DONE : ST_DIV_NUYX;
      ST_DIV_NUYX: if (div_last) state_nxt = ST_CHECK;
      ST_CHECK:    state_nxt = chk_err ? ST_DONE : ST_DIV_Q11;
      ST_DIV_Q11:  if (div_last) state_nxt = ST_DIV_Q22;
      ST_DIV_Q22:  if (div_last) state_nxt = ST_DIV_Q12;
      ST_DIV_Q12:  if (div_last) state_nxt = ST_DONE;
      ST_DONE:     state_nxt = ST_DONE;
      default:     state_nxt = ST_START;
    endcase
    if (cfg_we) state_nxt = ST_START;
  end

  always_comb begin
    div_load = 1'b0;
    div_run  = 1'b0;
    ld_num   = '0;
    ld_dsr   = '0;
    cap_q11  = 1'b0;
    cap_q22  = 1'b0;
    cap_q12  = 1'b0;
    case (state_r)
      ST_START: begin
        div_load = 1'b1;
        ld_num   = nuey_mag;
        ld_dsr   = mod_x_r;
      end
      ST_DIV_NUYX: div_run = 1'b1;
      ST_CHECK: begin
        div_load = 1'b1;
        ld_num   = DIV_W'({mod_x_r, {FRAC_BITS{1'b0}}});
        ld_dsr   = MOD_W'(den);
      end
      ST_DIV_Q11: begin
        if (div_last) begin
          cap_q11  = 1'b1;
          div_load = 1'b1;
          ld_num   = DIV_W'({mod_y_r, {FRAC_BITS{1'b0}}});
          ld_dsr   = dsr_r;
        end else begin
          div_run = 1'b1;
        end
      end
      ST_DIV_Q22: begin
        if (div_last) begin
          cap_q22  = 1'b1;
          div_load = 1'b1;
          ld_num   = nuey_mag;
          ld_dsr   = dsr_r;
        end else begin
          div_run = 1'b1;
        end
      end
      ST_DIV_Q12: begin
        if (div_last) begin
          cap_q12 = 1'b1;
        end else begin
          div_run = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      cnt_r   <= '0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (div_load) begin
        cnt_r <= '0;
      end else if (div_run) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == ST_START) begin
        err_r <= (mod_x_r == '0 || mod_y_r == '0);
      end else if (state_r == ST_CHECK && chk_err) begin
        err_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      num_r <= ld_num;
      rem_r <= '0;
      dsr_r <= ld_dsr;
    end else if (div_run) begin
      num_r <= num_step;
      rem_r <= rem_step;
    end
    if (cap_q11) q11_r <= q_pos;
    if (cap_q22) q22_r <= q_pos;
    if (cap_q12) q12_r <= nu_r[NU_W-1] ? q_neg : q_pos;
  end

  assign stf.ready = state_r == ST_DONE;
  assign stf.err   = err_r;
  assign stf.q11   = q11_r;
  assign stf.q12   = q12_r;
  assign stf.q22   = q22_r;
  assign stf.q66   = shear_r;

endmodule

FILE: hw/rtl/orthotropic_plane_stress_law.sv
// Top level: four-stage strain and stress pipeline fed by the stiffness unit.
// Depends on osl_pkg and osl_stiff.
//
//   channel | ports                          | payload
//   in      | in_valid, in_stall, in_word    | in_word_t, one material point
//   out     | out_valid, out_stall, out_word | out_word_t, one result
//   cfg     | cfg_we, cfg_index, cfg_wdata   | one register write
//
// One word per cycle sustained while out_stall is low and the stiffness unit
// is ready; the stages are squares, strain, stiffness products, and sum and
// saturation into the output register. After reset and after every register
// write the stiffness unit runs up to four divisions (fewer when the material
// is found unusable early); in_stall is high meanwhile.
// Each stage moves when the stage after it is empty or moving, so bubbles close
// up and an output stall backs up the pipeline without losing words.
module orthotropic_plane_stress_law import osl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MOD_W-1:0]     cfg_wdata
);

  localparam logic signed [65:0] ONE2 = 66'sd1 <<< (2 * FRAC_BITS);

  stiff_t stf;

  osl_stiff u_stiff (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .stf       (stf)
  );

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic en1, en2, en3, en4, in_acc;

  assign en4    = !s4_v_r || !out_stall;
  assign en3    = !s3_v_r || en4;
  assign en2    = !s2_v_r || en3;
  assign en1    = !s1_v_r || en2;
  assign in_stall = !en1 || !stf.ready;
  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= in_acc;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
      if (en4) s4_v_r <= s3_v_r;
    end
  end

  // Stage 1: squares and cross products of the deformation gradient.
  logic s1_grad_r, s1_ws_r, s1_wt_r;
  logic signed [WORD_W-1:0] s1_exx_r, s1_eyy_r, s1_gam_r;
  logic signed [63:0] s1_sq11_r, s1_sq21_r, s1_sq12_r, s1_sq22_r, s1_p1_r, s1_p2_r;
  logic signed [63:0] sq11, sq21, sq12, sq22, p1, p2;

  assign sq11 = in_word.grad_f11 * in_word.grad_f11;
  assign sq21 = in_word.grad_f21 * in_word.grad_f21;
  assign sq12 = in_word.grad_f12 * in_word.grad_f12;
  assign sq22 = in_word.grad_f22 * in_word.grad_f22;
  assign p1   = in_word.grad_f11 * in_word.grad_f12;
  assign p2   = in_word.grad_f21 * in_word.grad_f22;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_grad_r <= in_word.use_gradient;
      s1_ws_r   <= in_word.want_stress;
      s1_wt_r   <= in_word.want_tensor;
      s1_exx_r  <= in_word.strain_xx;
      s1_eyy_r  <= in_word.strain_yy;
      s1_gam_r  <= in_word.shear_strain;
      s1_sq11_r <= sq11;
      s1_sq21_r <= sq21;
      s1_sq12_r <= sq12;
      s1_sq22_r <= sq22;
      s1_p1_r   <= p1;
      s1_p2_r   <= p2;
    end
  end

  // Stage 2: Green-Lagrange strain, or the given strain.
  logic s2_ws_r, s2_wt_r;
  logic signed [WORD_W-1:0] s2_exx_r, s2_eyy_r, s2_gam_r;
  logic signed [65:0] dx, dy, gsum;

  assign dx   = 66'(s1_sq11_r) + 66'(s1_sq21_r) - ONE2;
  assign dy   = 66'(s1_sq12_r) + 66'(s1_sq22_r) - ONE2;
  assign gsum = 66'(s1_p1_r) + 66'(s1_p2_r);

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_ws_r  <= s1_ws_r;
      s2_wt_r  <= s1_wt_r;
      s2_exx_r <= s1_grad_r ? sat_word(dx >>> (FRAC_BITS + 1)) : s1_exx_r;
      s2_eyy_r <= s1_grad_r ? sat_word(dy >>> (FRAC_BITS + 1)) : s1_eyy_r;
      s2_gam_r <= s1_grad_r ? sat_word(gsum >>> FRAC_BITS) : s1_gam_r;
    end
  end

  // Stage 3: stiffness times strain.
  logic s3_ws_r, s3_wt_r;
  logic signed [WORD_W-1:0] s3_exx_r, s3_eyy_r, s3_gam_r;
  logic signed [63:0] s3_pa_r, s3_pb_r, s3_pc_r, s3_pd_r, s3_pg_r;
  logic signed [WORD_W-1:0] q66_s;

  assign q66_s = $signed({1'b0, stf.q66});

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_ws_r  <= s2_ws_r;
      s3_wt_r  <= s2_wt_r;
      s3_exx_r <= s2_exx_r;
      s3_eyy_r <= s2_eyy_r;
      s3_gam_r <= s2_gam_r;
      s3_pa_r  <= stf.q11 * s2_exx_r;
      s3_pb_r  <= stf.q12 * s2_eyy_r;
      s3_pc_r  <= stf.q12 * s2_exx_r;
      s3_pd_r  <= stf.q22 * s2_eyy_r;
      s3_pg_r  <= q66_s * s2_gam_r;
    end
  end

  // Stage 4: sums, scaling and saturation into the output register.
  logic signed [65:0] sum_x, sum_y, sum_g;
  out_word_t res, out_r;

  assign sum_x = 66'(s3_pa_r) + 66'(s3_pb_r);
  assign sum_y = 66'(s3_pc_r) + 66'(s3_pd_r);
  assign sum_g = 66'(s3_pg_r);

  always_comb begin
    res                  = '0;
    res.strain_xx_out    = s3_exx_r;
    res.strain_yy_out    = s3_eyy_r;
    res.shear_strain_out = s3_gam_r;
    res.material_error   = stf.err;
    if (!stf.err) begin
      if (s3_ws_r) begin
        res.stress_xx     = sat_word(sum_x >>> FRAC_BITS);
        res.stress_yy     = sat_word(sum_y >>> FRAC_BITS);
        res.shear_stress  = sat_word(sum_g >>> FRAC_BITS);
        res.valid_kind[0] = 1'b1;
      end
      if (s3_wt_r) begin
        res.stiff_11      = stf.q11;
        res.stiff_12      = stf.q12;
        res.stiff_22      = stf.q22;
        res.stiff_66      = stf.q66;
        res.valid_kind[1] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4) out_r <= res;
  end

  assign out_valid = s4_v_r;
  assign out_word  = out_r;

endmodule

FILE: hw/rtl/osl_chk.sv
// Port-level checker for the orthotropic plane-stress law, bound to the top level.
// Depends on osl_pkg and orthotropic_plane_stress_law.
module osl_chk import osl_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input out_word_t            out_word,
  input logic                 cfg_we
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_word))
    else $error("result word changed while stalled");

  // An unusable material reports nothing but the strain.
  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.material_error |-> out_word.valid_kind == 2'b00)
    else $error("valid_kind set with material error");

  a_stiff_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.valid_kind[1] |->
      out_word.stiff_11 == '0 && out_word.stiff_12 == '0 &&
      out_word.stiff_22 == '0 && out_word.stiff_66 == '0)
    else $error("stiffness fields not zero while unrequested");

  // A register write restarts the stiffness unit, which holds off input.
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("input accepted right after a register write");

endmodule

bind orthotropic_plane_stress_law osl_chk u_osl_chk (.*);

FILE: dv/orthotropic_plane_stress_law_test.sv
// Self-checking bench for orthotropic_plane_stress_law: random and directed words
// are checked against a predictor of strain, stiffness and stress. Depends on osl_pkg.
module orthotropic_plane_stress_law_test;
  import osl_pkg::*;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 600000;

  // Holds the material registers, predicts result words and checks them in order.
  class stress_scoreboard;
    logic [MOD_W-1:0] ex_reg = 31'd65536;
    logic [MOD_W-1:0] ey_reg = 31'd65536;
    logic [NU_W-1:0]  nu_reg = '0;
    logic [MOD_W-1:0] g_reg  = 31'd32768;
    out_word_t pending_q[$];
    int mismatches = 0;
    int accepted = 0;

    function void set_reg(cfg_idx_t idx, logic [MOD_W-1:0] v);
      case (idx)
        CFG_MODULUS_X:  ex_reg = v;
        CFG_MODULUS_Y:  ey_reg = v;
        CFG_POISSON_XY: nu_reg = v[NU_W-1:0];
        CFG_SHEAR_MOD:  g_reg  = v;
        default: ;
      endcase
    endfunction

    function longint sat32(longint v);
      if (v > WMAX) return WMAX;
      if (v < WMIN) return WMIN;
      return v;
    endfunction

    function longint half_stretch(longint a, longint b);
      longint unsigned ua, ub, sum;
      longint unsigned one2;
      longint d;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      sum = ua * ua + ub * ub;
      one2 = 64'd1 << (2 * FRAC_BITS);
      if (sum >= one2) d = longint'(sum - one2);
      else d = -longint'(one2 - sum);
      return sat32(d >>> (FRAC_BITS + 1));
    endfunction

    function out_word_t predict(in_word_t w);
      out_word_t r;
      longint exx, eyy, gam, p1, p2;
      longint ex, ey, nu, nuey, nuyx, den;
      longint q11, q12, q22, q66;
      longint unsigned an, ar, one2, prod;
      bit err;
      r = '0;
      err = 0;
      q11 = 0; q12 = 0; q22 = 0;
      ex = longint'(ex_reg);
      ey = longint'(ey_reg);
      nu = longint'($signed(nu_reg));
      q66 = longint'(g_reg);
      if (w.use_gradient) begin
        p1 = longint'(w.grad_f11) * longint'(w.grad_f12);
        p2 = longint'(w.grad_f21) * longint'(w.grad_f22);
        exx = half_stretch(w.grad_f11, w.grad_f21);
        eyy = half_stretch(w.grad_f12, w.grad_f22);
        if (p1 > 0 && p2 > 0 && p1 > 64'sh7FFFFFFFFFFFFFFF - p2) gam = WMAX;
        else gam = sat32((p1 + p2) >>> FRAC_BITS);
      end else begin
        exx = w.strain_xx;
        eyy = w.strain_yy;
        gam = w.shear_strain;
      end
      if (ex == 0 || ey == 0) begin
        err = 1;
      end else begin
        nuey = nu * ey;
        nuyx = nuey / ex;
        an = (nu < 0) ? -nu : nu;
        ar = (nuyx < 0) ? -nuyx : nuyx;
        one2 = 64'd1 << (2 * FRAC_BITS);
        prod = 0;
        if (an != 0) begin
          if (ar >= (one2 + an - 1) / an) err = 1;
          else prod = an * ar;
        end
        if (!err) begin
          den = (64'sd1 << FRAC_BITS) - longint'(prod >> FRAC_BITS);
          q11 = sat32(longint'((longint'(unsigned'(ex)) << FRAC_BITS) / den));
          q22 = sat32(longint'((longint'(unsigned'(ey)) << FRAC_BITS) / den));
          q12 = sat32(nuey / den);
        end
      end
      r.strain_xx_out    = exx[31:0];
      r.strain_yy_out    = eyy[31:0];
      r.shear_strain_out = gam[31:0];
      r.material_error   = err;
      if (!err) begin
        if (w.want_stress) begin
          r.stress_xx    = WORD_W'(sat32((q11 * exx + q12 * eyy) >>> FRAC_BITS));
          r.stress_yy    = WORD_W'(sat32((q12 * exx + q22 * eyy) >>> FRAC_BITS));
          r.shear_stress = WORD_W'(sat32((q66 * gam) >>> FRAC_BITS));
          r.valid_kind[0] = 1'b1;
        end
        if (w.want_tensor) begin
          r.stiff_11 = q11[31:0];
          r.stiff_12 = q12[31:0];
          r.stiff_22 = q22[31:0];
          r.stiff_66 = q66[MOD_W-1:0];
          r.valid_kind[1] = 1'b1;
        end
      end
      return r;
    endfunction

    function void note_input(in_word_t w);
      pending_q.insert(pending_q.size(), predict(w));
      accepted++;
    endfunction

    function void field(string name, longint e, longint a);
      if (e != a) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch %s: expected %h actual %h", name, e, a);
      end
    endfunction

    function void check_result(out_word_t a);
      out_word_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", a);
        return;
      end
      e = pending_q.pop_front();
      field("stress_xx", e.stress_xx, a.stress_xx);
      field("stress_yy", e.stress_yy, a.stress_yy);
      field("shear_stress", e.shear_stress, a.shear_stress);
      field("strain_xx_out", e.strain_xx_out, a.strain_xx_out);
      field("strain_yy_out", e.strain_yy_out, a.strain_yy_out);
      field("shear_strain_out", e.shear_strain_out, a.shear_strain_out);
      field("stiff_11", e.stiff_11, a.stiff_11);
      field("stiff_12", e.stiff_12, a.stiff_12);
      field("stiff_22", e.stiff_22, a.stiff_22);
      field("stiff_66", e.stiff_66, a.stiff_66);
      field("valid_kind", e.valid_kind, a.valid_kind);
      field("material_error", e.material_error, a.material_error);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MOD_W-1:0] cfg_wdata = '0;

  stress_scoreboard sb = new();
  int cycles = 0;
  int sent = 0;
  int hold_left = 0;
  bit held = 0;

  orthotropic_plane_stress_law uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Idling is switched off for a stretch of words in the middle of the run.
  function bit quiet_window();
    return sent >= 500 && sent < 700;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("orthotropic_plane_stress_law regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_word);
      if (in_valid && !in_stall) sb.note_input(in_word);
    end
  end

  // Receiver: random stalls, plus one long hold-off so the pipeline fills.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!held && sb.accepted >= 300) begin
      held <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet_window() && ($urandom_range(99) < 7);
    end
  end

  function logic [31:0] rand_value();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'd65536 + $urandom_range(0, 32767) - 16384;
      2: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $signed($urandom) >>> $urandom_range(8, 24);
    endcase
  endfunction

  function in_word_t rand_word();
    in_word_t w;
    w.use_gradient = 1'($urandom_range(1));
    w.want_stress  = 1'($urandom_range(1));
    w.want_tensor  = 1'($urandom_range(1));
    w.strain_xx    = rand_value();
    w.strain_yy    = rand_value();
    w.shear_strain = rand_value();
    w.grad_f11     = rand_value();
    w.grad_f12     = rand_value();
    w.grad_f21     = rand_value();
    w.grad_f22     = rand_value();
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    while (!quiet_window() && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [MOD_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic load_material(logic [MOD_W-1:0] ex, logic [MOD_W-1:0] ey,
                               logic [NU_W-1:0] nu, logic [MOD_W-1:0] g);
    write_reg(CFG_MODULUS_X, ex);
    write_reg(CFG_MODULUS_Y, ey);
    write_reg(CFG_POISSON_XY, {{(MOD_W-NU_W){nu[NU_W-1]}}, nu});
    write_reg(CFG_SHEAR_MOD, g);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function logic [MOD_W-1:0] rand_modulus();
    case ($urandom_range(3))
      0: return MOD_W'($urandom);
      1: return MOD_W'(65536 * $urandom_range(1, 300));
      2: return MOD_W'($urandom_range(1, 255));
      default: return 31'h7FFF_FFFF;
    endcase
  endfunction

  initial begin
    in_word_t w;
    logic [31:0] ext[4];
    ext[0] = 32'h8000_0000; ext[1] = 32'h7FFF_FFFF; ext[2] = 32'h0; ext[3] = 32'h0001_0000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every flag combination on extreme strains and gradients.
    for (int k = 0; k < 8; k++) begin
      w = '0;
      {w.use_gradient, w.want_stress, w.want_tensor} = k[2:0];
      w.strain_xx = ext[k % 4]; w.strain_yy = ext[(k + 1) % 4];
      w.shear_strain = ext[(k + 2) % 4];
      w.grad_f11 = ext[k % 4]; w.grad_f12 = ext[(k + 3) % 4];
      w.grad_f21 = ext[(k + 1) % 4]; w.grad_f22 = ext[(k + 2) % 4];
      send_word(w);
    end
    for (int k = 0; k < 4; k++) begin
      // Identity, all-most-negative and all-most-positive gradients, and zero F.
      w = '0;
      w.use_gradient = 1'b1; w.want_stress = 1'b1; w.want_tensor = 1'b1;
      w.grad_f11 = ext[k]; w.grad_f12 = ext[k]; w.grad_f21 = ext[k]; w.grad_f22 = ext[k];
      if (k == 3) begin
        w.grad_f12 = '0; w.grad_f21 = '0;
      end
      send_word(w);
    end
    for (int i = 0; i < 130; i++) send_word(rand_word());
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_material(31'd13107200, 31'd196608, 18'd19661, 31'd327680);
        1: load_material(31'h7FFF_FFFF, 31'd1, 18'h20000, 31'd0);
        2: load_material(31'h7FFF_FFFF, 31'h7FFF_FFFF, 18'h1FFFF, 31'h7FFF_FFFF);
        3: load_material(31'd0, 31'd65536, 18'd100, 31'd65536);
        4: load_material(31'd65536, 31'd0, 18'h3FF00, 31'd1);
        default: load_material(rand_modulus(), rand_modulus(), NU_W'($urandom),
                               rand_modulus());
      endcase
      for (int i = 0; i < 110; i++) send_word(rand_word());
      drain();
    end
    load_material(31'd65536, 31'd65536, 18'd0, 31'd32768);
    for (int i = 0; i < 40; i++) send_word(rand_word());
    drain();

    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("orthotropic_plane_stress_law regression: pass");
    end else begin
      $display("orthotropic_plane_stress_law regression: fail");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/osl_pkg.sv
hw/rtl/osl_stiff.sv
hw/rtl/orthotropic_plane_stress_law.sv
hw/rtl/osl_chk.sv
dv/orthotropic_plane_stress_law_test.sv
